// ===== design/asrl_pkg.sv =====
// Shared types, register codes and arithmetic helpers of the actuator slew-rate limiter.
package asrl_pkg;

  localparam logic signed [15:0] CMD_ONE     = 16'sd16384;
  localparam logic        [14:0] THRUST_ONE  = 15'd16384;
  localparam int unsigned        CFG_IDX_W   = 2;
  localparam int unsigned        CFG_DATA_W  = 16;

  localparam logic signed [15:0] ANGLE_MIN_RST   = -16'sd2458;
  localparam logic signed [15:0] ANGLE_MAX_RST   = 16'sd2458;
  localparam logic        [14:0] ANGLE_STEP_RST  = 15'd172;
  localparam logic        [14:0] THRUST_STEP_RST = 15'd164;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ANGLE_MIN   = 2'd0,
    REG_ANGLE_MAX   = 2'd1,
    REG_ANGLE_STEP  = 2'd2,
    REG_THRUST_STEP = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic signed [15:0] angle_min;
    logic signed [15:0] angle_max;
    logic        [14:0] angle_step_max;
    logic        [14:0] thrust_step_max;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] pitch_cmd;
    logic signed [15:0] yaw_cmd;
    logic signed [15:0] roll_cmd;
    logic        [14:0] thrust_cmd;
    logic               trigger_in;
    logic               alive;
  } cmd_t;

  typedef struct packed {
    logic signed [15:0] elevator;
    logic signed [15:0] rudder;
    logic signed [15:0] aileron;
    logic        [14:0] thrust;
    logic               trigger;
    logic               alive;
  } tgt_t;

  typedef struct packed {
    logic signed [15:0] elevator_angle;
    logic signed [15:0] rudder_angle;
    logic signed [15:0] aileron_angle;
    logic        [14:0] thrust_level;
    logic               gunfire;
  } res_t;

  function automatic logic signed [15:0] sat_cmd(input logic signed [15:0] c);
    logic signed [15:0] r;
    if (c > CMD_ONE) begin
      r = CMD_ONE;
    end else if (c < -CMD_ONE) begin
      r = -CMD_ONE;
    end else begin
      r = c;
    end
    return r;
  endfunction

  function automatic logic [14:0] sat_thrust(input logic [14:0] c);
    return (c > THRUST_ONE) ? THRUST_ONE : c;
  endfunction

  // (lo + hi + cmd*(hi - lo)) / 2 with cmd in Q1.14, rounded half up, saturated to 16 bits
  function automatic logic signed [15:0] map_angle(input logic signed [15:0] cmd,
                                                   input logic signed [15:0] lo,
                                                   input logic signed [15:0] hi);
    logic signed [16:0] sum;
    logic signed [16:0] dif;
    logic signed [32:0] prod;
    logic signed [33:0] num;
    logic signed [18:0] t;
    logic signed [15:0] r;
    sum  = {lo[15], lo} + {hi[15], hi};
    dif  = {hi[15], hi} - {lo[15], lo};
    prod = cmd * dif;
    num  = {{3{sum[16]}}, sum, 14'd0} + {prod[32], prod} + 34'sd16384;
    t    = num[33:15];
    if (t > 19'sd32767) begin
      r = 16'sh7fff;
    end else if (t < -19'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = t[15:0];
    end
    return r;
  endfunction

  function automatic logic signed [15:0] slew_angle(input logic signed [15:0] held,
                                                    input logic signed [15:0] tgt,
                                                    input logic        [14:0] step);
    logic signed [16:0] d;
    logic signed [16:0] s;
    logic signed [16:0] c;
    logic signed [16:0] r;
    d = {tgt[15], tgt} - {held[15], held};
    s = {2'b00, step};
    if (d > s) begin
      c = s;
    end else if (d < -s) begin
      c = -s;
    end else begin
      c = d;
    end
    r = {held[15], held} + c;
    return r[15:0];
  endfunction

  function automatic logic [14:0] slew_thrust(input logic [14:0] held,
                                              input logic [14:0] tgt,
                                              input logic [14:0] step);
    logic signed [15:0] d;
    logic signed [15:0] s;
    logic signed [15:0] c;
    logic signed [15:0] r;
    d = {1'b0, tgt} - {1'b0, held};
    s = {1'b0, step};
    if (d > s) begin
      c = s;
    end else if (d < -s) begin
      c = -s;
    end else begin
      c = d;
    end
    r = {1'b0, held} + c;
    return r[14:0];
  endfunction

endpackage

// ===== design/asrl_cmd_if.sv =====
// Command channel: valid/ready handshake carrying one tick of pilot commands.
interface asrl_cmd_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pitch_cmd;
  logic signed [15:0] yaw_cmd;
  logic signed [15:0] roll_cmd;
  logic        [14:0] thrust_cmd;
  logic               trigger_in;
  logic               alive;

  modport source (output valid, pitch_cmd, yaw_cmd, roll_cmd, thrust_cmd, trigger_in, alive,
                  input ready);
  modport sink   (input valid, pitch_cmd, yaw_cmd, roll_cmd, thrust_cmd, trigger_in, alive,
                  output ready);
endinterface

// ===== design/asrl_res_if.sv =====
// Result channel: valid/ready handshake carrying actuator positions for one tick.
interface asrl_res_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] elevator_angle;
  logic signed [15:0] rudder_angle;
  logic signed [15:0] aileron_angle;
  logic        [14:0] thrust_level;
  logic               gunfire;

  modport source (output valid, elevator_angle, rudder_angle, aileron_angle, thrust_level,
                  gunfire, input ready);
  modport sink   (input valid, elevator_angle, rudder_angle, aileron_angle, thrust_level,
                  gunfire, output ready);
endinterface

// ===== design/asrl_cfg.sv =====
// Configuration register file: deflection range and per-tick step limits.
module asrl_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [asrl_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [asrl_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  output asrl_pkg::cfg_t                      cfg_o
);
  import asrl_pkg::*;

  cfg_t cfg_q;
  cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_ANGLE_MIN:   cfg_d.angle_min       = cfg_wdata_i;
        REG_ANGLE_MAX:   cfg_d.angle_max       = cfg_wdata_i;
        REG_ANGLE_STEP:  cfg_d.angle_step_max  = cfg_wdata_i[14:0];
        REG_THRUST_STEP: cfg_d.thrust_step_max = cfg_wdata_i[14:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.angle_min       <= ANGLE_MIN_RST;
      cfg_q.angle_max       <= ANGLE_MAX_RST;
      cfg_q.angle_step_max  <= ANGLE_STEP_RST;
      cfg_q.thrust_step_max <= THRUST_STEP_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== design/asrl_target.sv =====
// Input register and target stage: saturate commands and map them onto the angle range.
module asrl_target (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  asrl_pkg::cmd_t    in_data_i,
  input  asrl_pkg::cfg_t    cfg_i,
  output logic              tgt_valid_o,
  input  logic              tgt_ready_i,
  output asrl_pkg::tgt_t    tgt_o
);
  import asrl_pkg::*;

  logic in_vld_q;
  cmd_t in_q;
  logic tgt_vld_q;
  tgt_t tgt_q;
  tgt_t tgt_d;
  logic tgt_load;

  assign tgt_load   = !tgt_vld_q || tgt_ready_i;
  assign in_ready_o = !in_vld_q || tgt_load;

  always_comb begin
    tgt_d.elevator = map_angle(sat_cmd(in_q.pitch_cmd), cfg_i.angle_min, cfg_i.angle_max);
    tgt_d.rudder   = map_angle(sat_cmd(in_q.yaw_cmd), cfg_i.angle_min, cfg_i.angle_max);
    tgt_d.aileron  = map_angle(sat_cmd(in_q.roll_cmd), cfg_i.angle_min, cfg_i.angle_max);
    tgt_d.thrust   = sat_thrust(in_q.thrust_cmd);
    tgt_d.trigger  = in_q.trigger_in;
    tgt_d.alive    = in_q.alive;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      tgt_vld_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (tgt_load) begin
        tgt_vld_q <= in_vld_q;
      end
    end
  end

  // Payload registers load only on a transfer into the stage
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
    if (in_vld_q && tgt_load) begin
      tgt_q <= tgt_d;
    end
  end

  assign tgt_valid_o = tgt_vld_q;
  assign tgt_o       = tgt_q;

endmodule

// ===== design/asrl_slew.sv =====
// Slew stage: move each held channel toward its target by the step limit; drives the result.
module asrl_slew (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              tgt_valid_i,
  output logic              tgt_ready_o,
  input  asrl_pkg::tgt_t    tgt_i,
  input  asrl_pkg::cfg_t    cfg_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output asrl_pkg::res_t    res_o
);
  import asrl_pkg::*;

  logic               out_vld_q;
  logic signed [15:0] elev_q;
  logic signed [15:0] rud_q;
  logic signed [15:0] ail_q;
  logic        [14:0] thr_q;
  logic               fire_q;
  logic signed [15:0] elev_d;
  logic signed [15:0] rud_d;
  logic signed [15:0] ail_d;
  logic        [14:0] thr_d;
  logic               fire_d;
  logic               adv;
  logic               take;

  assign adv         = !out_vld_q || out_ready_i;
  assign take        = tgt_valid_i && adv;
  assign tgt_ready_o = adv;

  always_comb begin
    if (tgt_i.alive) begin
      elev_d = slew_angle(elev_q, tgt_i.elevator, cfg_i.angle_step_max);
      rud_d  = slew_angle(rud_q, tgt_i.rudder, cfg_i.angle_step_max);
      ail_d  = slew_angle(ail_q, tgt_i.aileron, cfg_i.angle_step_max);
      thr_d  = slew_thrust(thr_q, tgt_i.thrust, cfg_i.thrust_step_max);
      fire_d = tgt_i.trigger;
    end else begin
      // drop everything to zero while not alive
      elev_d = '0;
      rud_d  = '0;
      ail_d  = '0;
      thr_d  = '0;
      fire_d = 1'b0;
    end
  end

  // Held values double as the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      elev_q    <= '0;
      rud_q     <= '0;
      ail_q     <= '0;
      thr_q     <= '0;
      fire_q    <= 1'b0;
    end else begin
      if (adv) begin
        out_vld_q <= tgt_valid_i;
      end
      if (take) begin
        elev_q <= elev_d;
        rud_q  <= rud_d;
        ail_q  <= ail_d;
        thr_q  <= thr_d;
        fire_q <= fire_d;
      end
    end
  end

  assign out_valid_o          = out_vld_q;
  assign res_o.elevator_angle = elev_q;
  assign res_o.rudder_angle   = rud_q;
  assign res_o.aileron_angle  = ail_q;
  assign res_o.thrust_level   = thr_q;
  assign res_o.gunfire        = fire_q;

endmodule

// ===== design/actuator_slew_rate_limiter.sv =====
// A transferred command moves from the input register to the target register, then to the result register.
// Throughput: one item per cycle; input register, target register (one 16x17 multiply
//   per angle channel) and result register form a stall-capable three-stage pipeline.
// Ready on the command side deasserts only when all three stages are full and the
//   result is not being taken.
// Reset (async, active low): pipeline empty, held positions zero, registers to defaults.
module actuator_slew_rate_limiter (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  asrl_cmd_if.sink                           cmd_i,
  asrl_res_if.source                         res_o,
  input  logic                               cfg_we_i,
  input  logic [asrl_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [asrl_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);
  import asrl_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  tgt_t tgt;
  res_t res;
  logic tgt_valid;
  logic tgt_ready;

  assign cmd.pitch_cmd  = cmd_i.pitch_cmd;
  assign cmd.yaw_cmd    = cmd_i.yaw_cmd;
  assign cmd.roll_cmd   = cmd_i.roll_cmd;
  assign cmd.thrust_cmd = cmd_i.thrust_cmd;
  assign cmd.trigger_in = cmd_i.trigger_in;
  assign cmd.alive      = cmd_i.alive;

  asrl_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  asrl_target u_target (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (cmd_i.valid),
    .in_ready_o  (cmd_i.ready),
    .in_data_i   (cmd),
    .cfg_i       (cfg),
    .tgt_valid_o (tgt_valid),
    .tgt_ready_i (tgt_ready),
    .tgt_o       (tgt)
  );

  asrl_slew u_slew (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tgt_valid_i (tgt_valid),
    .tgt_ready_o (tgt_ready),
    .tgt_i       (tgt),
    .cfg_i       (cfg),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .res_o       (res)
  );

  assign res_o.elevator_angle = res.elevator_angle;
  assign res_o.rudder_angle   = res.rudder_angle;
  assign res_o.aileron_angle  = res.aileron_angle;
  assign res_o.thrust_level   = res.thrust_level;
  assign res_o.gunfire        = res.gunfire;

endmodule

// ===== design/asrl_checker.sv =====
// Port-level checker for the actuator slew-rate limiter and its bind to the top level.
module asrl_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic signed [15:0] elevator_angle_i,
  input logic signed [15:0] rudder_angle_i,
  input logic signed [15:0] aileron_angle_i,
  input logic        [14:0] thrust_level_i,
  input logic               gunfire_i
);
  import asrl_pkg::*;

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(elevator_angle_i) &&
      $stable(rudder_angle_i) && $stable(aileron_angle_i) && $stable(thrust_level_i) &&
      $stable(gunfire_i))
    else $error("result changed while stalled");

  // Back-pressure at the input only comes from a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input ready low without output stall");

  // Thrust never leaves its range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> thrust_level_i <= THRUST_ONE)
    else $error("thrust level above full scale");

  // Nothing is presented right after reset
  assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_i)
    else $error("result valid out of reset");

  // Ready is asserted when the pipeline is idle and waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i && !in_valid_i |=> in_ready_i || out_valid_i)
    else $error("input stalled with empty output");

endmodule

bind actuator_slew_rate_limiter asrl_checker u_asrl_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (cmd_i.valid),
  .in_ready_i       (cmd_i.ready),
  .out_valid_i      (res_o.valid),
  .out_ready_i      (res_o.ready),
  .elevator_angle_i (res_o.elevator_angle),
  .rudder_angle_i   (res_o.rudder_angle),
  .aileron_angle_i  (res_o.aileron_angle),
  .thrust_level_i   (res_o.thrust_level),
  .gunfire_i        (res_o.gunfire)
);

// ===== tb/actuator_slew_rate_limiter_tb.sv =====
// Self-checking testbench of the actuator slew-rate limiter with a cycle-free position predictor.
`timescale 1ns / 100ps

module actuator_slew_rate_limiter_tb;
  import asrl_pkg::*;

  localparam int PIPE_LATENCY = 3;
  localparam int HOLD_CYCLES  = 300;
  localparam int IDLE_PCT     = 26;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  asrl_cmd_if cmd_if ();
  asrl_res_if res_if ();

  actuator_slew_rate_limiter i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cmd_i       (cmd_if),
    .res_o       (res_if),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  // Predictor state: register copy and held actuator positions
  cfg_t model_cfg;
  int   elev_pos;
  int   rudder_pos;
  int   aileron_pos;
  int   thrust_pos;
  res_t expected_positions[$];
  int   error_count;

  bit   src_gaps;
  bit   sink_gaps;
  logic hold_req;

  always #5 clk = ~clk;

  function automatic cfg_t settings(int lo, int hi, int angle_step, int thrust_step);
    cfg_t s;
    s.angle_min       = lo[15:0];
    s.angle_max       = hi[15:0];
    s.angle_step_max  = angle_step[14:0];
    s.thrust_step_max = thrust_step[14:0];
    return s;
  endfunction

  function automatic cmd_t make_cmd(int p, int y, int r, int t, bit trig, bit alive);
    cmd_t c;
    c.pitch_cmd  = p[15:0];
    c.yaw_cmd    = y[15:0];
    c.roll_cmd   = r[15:0];
    c.thrust_cmd = t[14:0];
    c.trigger_in = trig;
    c.alive      = alive;
    return c;
  endfunction

  // Map a command onto [angle_min, angle_max], round half up, saturate
  function automatic int target_angle(logic signed [15:0] cmd);
    longint lo;
    longint hi;
    longint c;
    longint num;
    longint t;
    lo = $signed(model_cfg.angle_min);
    hi = $signed(model_cfg.angle_max);
    c  = $signed(cmd);
    if (c > int'(CMD_ONE)) begin
      c = int'(CMD_ONE);
    end else if (c < -int'(CMD_ONE)) begin
      c = -int'(CMD_ONE);
    end
    num = (lo + hi) * 16384 + c * (hi - lo) + 16384;
    t   = num >>> 15;
    if (t > 32767) begin
      t = 32767;
    end else if (t < -32768) begin
      t = -32768;
    end
    return int'(t);
  endfunction

  function automatic int slew_toward(int held, int tgt, int step);
    int d;
    d = tgt - held;
    if (d > step) begin
      d = step;
    end else if (d < -step) begin
      d = -step;
    end
    return held + d;
  endfunction

  task automatic predict_positions(cmd_t c);
    res_t r;
    int   thr;
    r.gunfire = 1'b0;
    if (c.alive) begin
      elev_pos    = slew_toward(elev_pos, target_angle(c.pitch_cmd),
                                int'(model_cfg.angle_step_max));
      rudder_pos  = slew_toward(rudder_pos, target_angle(c.yaw_cmd),
                                int'(model_cfg.angle_step_max));
      aileron_pos = slew_toward(aileron_pos, target_angle(c.roll_cmd),
                                int'(model_cfg.angle_step_max));
      thr = (int'(c.thrust_cmd) > int'(THRUST_ONE)) ? int'(THRUST_ONE) : int'(c.thrust_cmd);
      thrust_pos  = slew_toward(thrust_pos, thr, int'(model_cfg.thrust_step_max));
      r.gunfire   = c.trigger_in;
    end else begin
      elev_pos    = 0;
      rudder_pos  = 0;
      aileron_pos = 0;
      thrust_pos  = 0;
    end
    r.elevator_angle = elev_pos[15:0];
    r.rudder_angle   = rudder_pos[15:0];
    r.aileron_angle  = aileron_pos[15:0];
    r.thrust_level   = thrust_pos[14:0];
    expected_positions.push_back(r);
  endtask

  // Predict on every command transfer
  always @(posedge clk) begin : track_commands
    cmd_t c;
    if (rst_n && cmd_if.valid && cmd_if.ready) begin
      c.pitch_cmd  = cmd_if.pitch_cmd;
      c.yaw_cmd    = cmd_if.yaw_cmd;
      c.roll_cmd   = cmd_if.roll_cmd;
      c.thrust_cmd = cmd_if.thrust_cmd;
      c.trigger_in = cmd_if.trigger_in;
      c.alive      = cmd_if.alive;
      predict_positions(c);
    end
  end

  task automatic check_field(string field, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin : check_results
    res_t want;
    if (rst_n && res_if.valid && res_if.ready) begin
      if (expected_positions.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual elevator %0d thrust %0d",
                 $time, res_if.elevator_angle, res_if.thrust_level);
        error_count++;
      end else begin
        want = expected_positions.pop_front();
        check_field("elevator_angle", $signed(want.elevator_angle), $signed(res_if.elevator_angle));
        check_field("rudder_angle", $signed(want.rudder_angle), $signed(res_if.rudder_angle));
        check_field("aileron_angle", $signed(want.aileron_angle), $signed(res_if.aileron_angle));
        check_field("thrust_level", want.thrust_level, res_if.thrust_level);
        check_field("gunfire", want.gunfire, res_if.gunfire);
      end
    end
  end

  // Result side: random stalls, plus a long hold-off on request
  initial begin : drive_result_ready
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req     <= 1'b0;
        res_if.ready <= 1'b0;
        for (int n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
        res_if.ready <= 1'b1;
      end else begin
        res_if.ready <= !sink_gaps || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Call at a rising edge; returns at the edge of the transfer with valid still high
  task automatic send_cmd(cmd_t c);
    if (src_gaps) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        cmd_if.valid <= 1'b0;
        @(posedge clk);
      end
    end
    cmd_if.valid      <= 1'b1;
    cmd_if.pitch_cmd  <= c.pitch_cmd;
    cmd_if.yaw_cmd    <= c.yaw_cmd;
    cmd_if.roll_cmd   <= c.roll_cmd;
    cmd_if.thrust_cmd <= c.thrust_cmd;
    cmd_if.trigger_in <= c.trigger_in;
    cmd_if.alive      <= c.alive;
    do @(posedge clk); while (!cmd_if.ready);
  endtask

  task automatic wait_drained();
    cmd_if.valid <= 1'b0;
    @(posedge clk);
    while (expected_positions.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      REG_ANGLE_MIN:   model_cfg.angle_min       = data;
      REG_ANGLE_MAX:   model_cfg.angle_max       = data;
      REG_ANGLE_STEP:  model_cfg.angle_step_max  = data[14:0];
      REG_THRUST_STEP: model_cfg.thrust_step_max = data[14:0];
      default: ;
    endcase
    cfg_we <= 1'b0;
  endtask

  // The top bit of the step registers lies outside the field: set it at random
  task automatic apply_settings(cfg_t s);
    write_reg(REG_ANGLE_MIN, s.angle_min);
    write_reg(REG_ANGLE_MAX, s.angle_max);
    write_reg(REG_ANGLE_STEP, {1'($urandom_range(1)), s.angle_step_max});
    write_reg(REG_THRUST_STEP, {1'($urandom_range(1)), s.thrust_step_max});
  endtask

  function automatic int rand_limit();
    int v;
    case ($urandom_range(9))
      0:       v = -32768;
      1:       v = 32767;
      2, 3:    v = int'($urandom_range(65535)) - 32768;
      default: v = int'($urandom_range(8000)) - 4000;
    endcase
    return v;
  endfunction

  function automatic cfg_t rand_settings();
    int lo;
    int hi;
    int a_step;
    int t_step;
    int tmp;
    lo = rand_limit();
    hi = rand_limit();
    if (lo > hi && $urandom_range(3) != 0) begin
      tmp = lo;
      lo  = hi;
      hi  = tmp;
    end
    case ($urandom_range(9))
      0:       a_step = 0;
      1:       a_step = 32767;
      2:       a_step = $urandom_range(32767);
      default: a_step = $urandom_range(600, 1);
    endcase
    case ($urandom_range(9))
      0:       t_step = 0;
      1:       t_step = int'(THRUST_ONE);
      2:       t_step = $urandom_range(int'(THRUST_ONE));
      default: t_step = $urandom_range(600, 1);
    endcase
    return settings(lo, hi, a_step, t_step);
  endfunction

  function automatic logic signed [15:0] rand_angle_cmd();
    int v;
    case ($urandom_range(9))
      0:       v = int'(CMD_ONE);
      1:       v = -int'(CMD_ONE);
      2, 3:    v = $urandom_range(65535);
      default: v = int'($urandom_range(32768)) - 16384;
    endcase
    return v[15:0];
  endfunction

  function automatic logic [14:0] rand_thrust_cmd();
    int v;
    case ($urandom_range(9))
      0:       v = 0;
      1:       v = int'(THRUST_ONE);
      2, 3:    v = $urandom_range(32767);
      default: v = $urandom_range(int'(THRUST_ONE));
    endcase
    return v[14:0];
  endfunction

  // Hold a command for a run of ticks so the outputs slew toward it; mix in deaths and noise
  task automatic drive_random(int count);
    cmd_t base;
    cmd_t c;
    int   left;
    left = 0;
    for (int i = 0; i < count; i++) begin
      if (left == 0) begin
        base.pitch_cmd  = rand_angle_cmd();
        base.yaw_cmd    = rand_angle_cmd();
        base.roll_cmd   = rand_angle_cmd();
        base.thrust_cmd = rand_thrust_cmd();
        base.alive      = 1'b1;
        left = $urandom_range(16, 1);
      end
      c = base;
      c.trigger_in = 1'($urandom_range(1));
      if ($urandom_range(19) == 0) begin
        c.alive = 1'b0;
      end else if ($urandom_range(9) == 0) begin
        c = make_cmd($urandom_range(65535), $urandom_range(65535), $urandom_range(65535),
                     $urandom_range(32767), 1'($urandom_range(1)), 1'($urandom_range(1)));
      end
      send_cmd(c);
      left--;
    end
  endtask

  task automatic test_default_limits();
    send_cmd(make_cmd(16384, -16384, 0, 16384, 1'b1, 1'b1));
    send_cmd(make_cmd(32767, -32768, 1, 32767, 1'b0, 1'b1));
    send_cmd(make_cmd(-1, 16383, -16383, 1, 1'b1, 1'b1));
    // dead: trigger must not reach the guns
    send_cmd(make_cmd(0, 0, 0, 0, 1'b1, 1'b0));
    send_cmd(make_cmd(-16385, 16385, 8192, 16385, 1'b1, 1'b1));
    send_cmd(make_cmd(16384, 16384, 16384, 16384, 1'b0, 1'b1));
    wait_drained();
  endtask

  task automatic test_register_extremes();
    // full range, largest angle step and a full-scale thrust step
    apply_settings(settings(-32768, 32767, 32767, int'(THRUST_ONE)));
    send_cmd(make_cmd(16384, -16384, 0, 16384, 1'b1, 1'b1));
    send_cmd(make_cmd(-16384, 16384, 1, 0, 1'b0, 1'b1));
    send_cmd(make_cmd(-1, 32767, -32768, 32767, 1'b1, 1'b1));
    send_cmd(make_cmd(0, 0, 0, 0, 1'b0, 1'b0));
    wait_drained();
    // inverted range
    apply_settings(settings(3000, -5000, 32767, int'(THRUST_ONE)));
    send_cmd(make_cmd(16384, -16384, 0, 100, 1'b1, 1'b1));
    send_cmd(make_cmd(-16384, 5, -5, 16384, 1'b0, 1'b1));
    wait_drained();
    // zero steps: held values stay put until death clears them
    apply_settings(settings(-2458, 2458, 0, 0));
    send_cmd(make_cmd(16384, -16384, 16384, 0, 1'b1, 1'b1));
    send_cmd(make_cmd(0, 0, 0, 16384, 1'b0, 1'b0));
    send_cmd(make_cmd(16384, 0, 0, 16384, 1'b1, 1'b1));
    wait_drained();
    // collapsed range
    apply_settings(settings(1000, 1000, 500, 1));
    send_cmd(make_cmd(16384, -16384, 0, 16384, 1'b1, 1'b1));
    send_cmd(make_cmd(-1, 1, 0, 16384, 1'b0, 1'b1));
    wait_drained();
  endtask

  task automatic test_random_flight();
    for (int phase = 0; phase < 6; phase++) begin
      apply_settings(rand_settings());
      drive_random(110);
      wait_drained();
    end
  endtask

  task automatic test_steady_stream();
    src_gaps  = 1'b0;
    sink_gaps = 1'b0;
    apply_settings(rand_settings());
    drive_random(150);
    wait_drained();
    src_gaps  = 1'b1;
    sink_gaps = 1'b1;
  endtask

  // Stall the result side while commands keep coming so the pipeline fills
  task automatic test_output_backpressure();
    apply_settings(settings(-4000, 4000, 300, 300));
    hold_req <= 1'b1;
    drive_random(40);
    wait_drained();
  endtask

  initial begin : run_tests
    clk         = 1'b0;
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_idx     = REG_ANGLE_MIN;
    cfg_wdata   = '0;
    cmd_if.valid      = 1'b0;
    cmd_if.pitch_cmd  = '0;
    cmd_if.yaw_cmd    = '0;
    cmd_if.roll_cmd   = '0;
    cmd_if.thrust_cmd = '0;
    cmd_if.trigger_in = 1'b0;
    cmd_if.alive      = 1'b0;
    hold_req    = 1'b0;
    src_gaps    = 1'b1;
    sink_gaps   = 1'b1;
    error_count = 0;
    model_cfg   = settings(ANGLE_MIN_RST, ANGLE_MAX_RST, ANGLE_STEP_RST, THRUST_STEP_RST);
    elev_pos    = 0;
    rudder_pos  = 0;
    aileron_pos = 0;
    thrust_pos  = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_default_limits();
    test_register_extremes();
    test_random_flight();
    test_steady_stream();
    test_output_backpressure();
    wait_drained();
    if (error_count == 0 && expected_positions.size() == 0) begin
      $display("actuator_slew_rate_limiter test passed");
    end else begin
      $display("actuator_slew_rate_limiter test failed");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("actuator_slew_rate_limiter test failed");
    $finish;
  end

endmodule

// ===== files.f =====
design/asrl_pkg.sv
design/asrl_cmd_if.sv
design/asrl_res_if.sv
design/asrl_cfg.sv
design/asrl_target.sv
design/asrl_slew.sv
design/actuator_slew_rate_limiter.sv
design/asrl_checker.sv
tb/actuator_slew_rate_limiter_tb.sv
